@@ hdl/w3f_pkg.sv @@
// Package for the 3x3 sobel/sharpen window filter.
// Holds payload types, register indexes and the pixel constants; no dependencies.
package w3f_pkg;

  localparam int unsigned PIX_W = 8;
  localparam int unsigned SIZE_W = 12;
  localparam logic [7:0] PIX_MAX = 8'd255;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_FILTER = 2'd2,
    REG_COLOR  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;
    logic       is_pad;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out0;
    logic [7:0] out1;
    logic [7:0] out2;
    logic       end_of_image;
  } pix_out_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [11:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic       sharpen;
    logic       color;
    logic       last;
  } ctl_t;

endpackage

@@ hdl/w3f_if.sv @@
// Valid/ready channel interfaces for the window filter.
// Depends on w3f_pkg for payload types.
interface w3f_pix_in_if;
  logic             valid;
  logic             ready;
  w3f_pkg::pix_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface w3f_pix_out_if;
  logic              valid;
  logic              ready;
  w3f_pkg::pix_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface w3f_cfg_if;
  logic             valid;
  logic             ready;
  w3f_pkg::cfg_wr_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/window_3x3_sobel_sharpen_filter.sv @@
// 3x3 sobel magnitude / sharpen filter over a raster stream.
// Depends on w3f_pkg, w3f_if, w3f_window, w3f_lane and w3f_isqrt.
//
// Send (height+1) x (width+1) pixel beats in raster order; the last column and
// row are padding. Each beat at row and column of at least 1 yields one output
// beat for the pixel up and to the left. One window step plus three channel
// lanes in a 7-stage pipeline (one window stage, two arithmetic stages, four
// root stages) process one beat at a time: a beat that yields a result is
// followed by its output beat once it leaves the last root stage, and
// the next input beat is taken the cycle after the output beat leaves; a beat
// with no result lets the next one in once step_pending clears. Line stores
// are two (MAX_WIDTH+1)-entry memories read into registers at the column
// counter, so the input holds off while step_pending is set after reset
// and after any configuration write. Any configuration write restarts the frame.
module window_3x3_sobel_sharpen_filter #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input logic        clk,
  input logic        rst,
  w3f_pix_in_if.sink   pix_in,
  w3f_pix_out_if.source pix_out,
  w3f_cfg_if.sink      cfg
);
  logic [11:0] image_width, image_height;
  logic        filter_mode, color_mode;
  logic        busy;
  logic        step_pending;
  logic        step, cfg_wr, emit, last;
  w3f_pkg::ctl_t ctl;
  logic [215:0] win;
  logic [6:1]  vld;
  w3f_pkg::ctl_t c [1:6];
  logic [5:0]  en;
  logic [7:0]  lp [0:2];

  assign pix_in.ready = !busy && !cfg.valid;
  assign cfg.ready = !busy;
  assign step = pix_in.valid && pix_in.ready;
  assign cfg_wr = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= 12'd1;
      image_height <= 12'd1;
      filter_mode <= 1'b0;
      color_mode <= 1'b0;
    end else if (cfg_wr) begin
      unique case (w3f_pkg::reg_idx_t'(cfg.data.index))
        w3f_pkg::REG_WIDTH:  image_width <= cfg.data.data;
        w3f_pkg::REG_HEIGHT: image_height <= cfg.data.data;
        w3f_pkg::REG_FILTER: filter_mode <= cfg.data.data[0];
        w3f_pkg::REG_COLOR:  color_mode <= cfg.data.data[0];
        default: ;
      endcase
    end
  end

  w3f_window #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_win (
    .clk(clk), .rst(rst), .restart(cfg_wr), .step(step), .pin(pix_in.data),
    .image_width(image_width), .image_height(image_height),
    .win(win), .emit(emit), .last(last)
  );

  assign ctl = '{sharpen: filter_mode, color: color_mode, last: last};

  // stages 1..6 hold a result in flight
  assign busy = step_pending || (|vld[6:1]) || pix_out.valid;
  always_ff @(posedge clk) begin
    if (rst) step_pending <= 1'b1;
    else step_pending <= step || cfg_wr;
  end

  always_comb begin
    en[0] = emit;
    for (int s = 1; s < 6; s++) en[s] = vld[s];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld[1] <= emit;
      for (int s = 2; s < 7; s++) vld[s] <= vld[s-1];
      if (vld[6] && !pix_out.ready) vld[6] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) c[1] <= ctl;
    for (int s = 2; s < 7; s++) if (vld[s-1]) c[s] <= c[s-1];
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    w3f_lane u_lane (
      .clk(clk), .en(en), .sharpen(ctl.sharpen),
      .win({win[24*8+8*g +: 8], win[24*7+8*g +: 8], win[24*6+8*g +: 8],
            win[24*5+8*g +: 8], win[24*4+8*g +: 8], win[24*3+8*g +: 8],
            win[24*2+8*g +: 8], win[24*1+8*g +: 8], win[8*g +: 8]}),
      .pix(lp[g])
    );
  end

  assign pix_out.valid = vld[6];
  assign pix_out.data.out0 = lp[0];
  assign pix_out.data.out1 = c[6].color ? lp[1] : 8'd0;
  assign pix_out.data.out2 = c[6].color ? lp[2] : 8'd0;
  assign pix_out.data.end_of_image = c[6].last;
endmodule

@@ hdl/w3f_isqrt.sv @@
// Pipelined integer square root, two result bits per stage, saturated to 255.
// Depends on w3f_pkg; stage enables come from the lane owner.
module w3f_isqrt (
  input  logic        clk,
  input  logic [3:0]  en,
  input  logic [20:0] sq,
  output logic [7:0]  root
);
  // radicand up to 2*1020^2; anything at or above 2^16 saturates, so the
  // stages work on the low 16 bits and carry a saturate flag
  logic [15:0] rem_q [1:3];
  logic [7:0]  res_q [1:4];
  logic        sat_q [1:4];
  logic [15:0] rem_i [0:3];
  logic [7:0]  res_i [0:3];
  logic        sat_i [0:3];
  logic [15:0] rem_n [0:3];
  logic [7:0]  res_n [0:3];

  always_comb begin
    rem_i[0] = sq[15:0];
    res_i[0] = '0;
    sat_i[0] = |sq[20:16];
    for (int s = 1; s < 4; s++) begin
      rem_i[s] = rem_q[s];
      res_i[s] = res_q[s];
      sat_i[s] = sat_q[s];
    end
  end

  always_comb begin
    for (int s = 0; s < 4; s++) begin
      logic [15:0] r;
      logic [7:0]  q;
      logic [17:0] t;
      r = rem_i[s];
      q = res_i[s];
      for (int k = 0; k < 2; k++) begin
        t = ({10'd0, q} << (8 - 2 * s - k)) + (18'd1 << (2 * (7 - 2 * s - k)));
        if ({2'd0, r} >= t) begin
          r = r - t[15:0];
          q = q | (8'd1 << (7 - 2 * s - k));
        end
      end
      rem_n[s] = r;
      res_n[s] = q;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < 3; s++) begin
      if (en[s]) rem_q[s+1] <= rem_n[s];
    end
    for (int s = 0; s < 4; s++) begin
      if (en[s]) begin
        res_q[s+1] <= res_n[s];
        sat_q[s+1] <= sat_i[s];
      end
    end
  end

  assign root = sat_q[4] ? w3f_pkg::PIX_MAX : res_q[4];
endmodule

@@ hdl/w3f_lane.sv @@
// One channel lane: sobel gradients and sharpen sum, then root and clamp.
// Depends on w3f_pkg and w3f_isqrt; a 6-stage pipeline moved by en.
module w3f_lane (
  input  logic        clk,
  input  logic [5:0]  en,
  input  logic        sharpen,
  input  logic [71:0] win,
  output logic [7:0]  pix
);
  logic [7:0] p [0:8];
  logic signed [11:0] gx, gy, sh;
  logic [23:0] gx2, gy2;
  logic [20:0] sq;
  logic        shp [0:5];
  logic [7:0]  shv [1:5];
  logic [7:0]  root;

  always_comb begin
    for (int k = 0; k < 9; k++) p[k] = win[8*k +: 8];
  end

  assign gx2 = 24'(gx * gx);
  assign gy2 = 24'(gy * gy);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      gx <= $signed({4'd0, p[0]}) - $signed({4'd0, p[2]})
          + $signed({3'd0, p[3], 1'b0}) - $signed({3'd0, p[5], 1'b0})
          + $signed({4'd0, p[6]}) - $signed({4'd0, p[8]});
      gy <= $signed({4'd0, p[0]}) + $signed({3'd0, p[1], 1'b0}) + $signed({4'd0, p[2]})
          - $signed({4'd0, p[6]}) - $signed({3'd0, p[7], 1'b0}) - $signed({4'd0, p[8]});
      sh <= $signed({4'd0, p[4]}) * 12'sd5 - $signed({4'd0, p[1]})
          - $signed({4'd0, p[3]}) - $signed({4'd0, p[5]}) - $signed({4'd0, p[7]});
      shp[0] <= sharpen;
    end
    if (en[1]) begin
      sq <= 21'(gx2) + 21'(gy2);
      shp[1] <= shp[0];
      shv[1] <= sh[11] ? 8'd0 : (sh > 12'sd255 ? w3f_pkg::PIX_MAX : sh[7:0]);
    end
    for (int s = 2; s < 6; s++) begin
      if (en[s]) begin
        shp[s] <= shp[s-1];
        shv[s] <= shv[s-1];
      end
    end
  end

  w3f_isqrt u_sqrt (.clk(clk), .en(en[5:2]), .sq(sq), .root(root));

  assign pix = shp[5] ? shv[5] : root;
endmodule

@@ hdl/w3f_window.sv @@
// Line stores, raster counters and 3x3 window for the filter.
// Depends on w3f_pkg; feeds the lanes with the window and per-beat control.
module w3f_window #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              restart,
  input  logic              step,
  input  w3f_pkg::pix_in_t  pin,
  input  logic [11:0]       image_width,
  input  logic [11:0]       image_height,
  output logic [215:0]      win,
  output logic              emit,
  output logic              last
);
  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned DEPTH = MAX_WIDTH + 1;

  logic [23:0] mem_up [0:DEPTH-1];
  logic [23:0] mem_lo [0:DEPTH-1];
  logic [23:0] up_q, lo_q;
  logic [CW-1:0] col, col_next, wid;
  logic [RW-1:0] row, row_next, hgt;
  logic [23:0] w [0:8];
  logic [23:0] v, top, mid;

  always_comb begin
    if (image_width == 12'd0) wid = CW'(1);
    else if (32'(image_width) > MAX_WIDTH) wid = CW'(MAX_WIDTH);
    else wid = CW'(image_width);
    if (image_height == 12'd0) hgt = RW'(1);
    else if (32'(image_height) > MAX_HEIGHT) hgt = RW'(MAX_HEIGHT);
    else hgt = RW'(image_height);
  end

  always_comb begin
    v = (!pin.is_pad && col < wid && row < hgt) ? {pin.chan2, pin.chan1, pin.chan0} : '0;
    top = (row >= RW'(2)) ? up_q : '0;
    mid = (row >= RW'(1)) ? lo_q : '0;
    if (col == wid) begin
      col_next = '0;
      row_next = (row == hgt) ? '0 : row + RW'(1);
    end else begin
      col_next = col + CW'(1);
      row_next = row;
    end
  end

  // read at the column counter every cycle; a beat follows only after the read is registered
  always_ff @(posedge clk) begin
    up_q <= mem_up[col];
    lo_q <= mem_lo[col];
    if (step) begin
      mem_up[col] <= lo_q;
      mem_lo[col] <= v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
      for (int k = 0; k < 9; k++) w[k] <= '0;
      emit <= 1'b0;
      last <= 1'b0;
    end else begin
      emit <= 1'b0;
      if (step) begin
        col <= col_next;
        row <= row_next;
        w[0] <= (col == '0) ? '0 : w[1];
        w[1] <= (col == '0) ? '0 : w[2];
        w[2] <= top;
        w[3] <= (col == '0) ? '0 : w[4];
        w[4] <= (col == '0) ? '0 : w[5];
        w[5] <= mid;
        w[6] <= (col == '0) ? '0 : w[7];
        w[7] <= (col == '0) ? '0 : w[8];
        w[8] <= v;
        emit <= (row != '0) && (col != '0);
        last <= (row == hgt) && (col == wid);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 9; k++) win[24*k +: 24] = w[k];
  end
endmodule
